// File: design/bbec_pkg.sv
package bbec_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_KERNEL  = 15;

    localparam int COORD_W     = 8;
    localparam int DIM_W       = 9;
    localparam int KERNEL_W    = 4;
    localparam int RAD_W       = 3;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int PIX_ADDR_W  = 2 * COORD_W;
    localparam int CNT_W       = 8;
    localparam int SUM_W       = 16;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRAY   = 2'd2;
    localparam logic [1:0] REG_KERNEL = 2'd3;

    // Request codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_BLUR  = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic                gray_input;
        logic [KERNEL_W-1:0] win_len;
    } cfg_t;

endpackage

// File: design/bbec_cfg.sv
module bbec_cfg
    import bbec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= DIM_W'(256);
            cfg_reg.image_height <= DIM_W'(256);
            cfg_reg.gray_input   <= 1'b0;
            cfg_reg.win_len      <= KERNEL_W'(5);
        end else if (wr_en) begin
            case (reg_index)
                REG_WIDTH:  cfg_reg.image_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: cfg_reg.image_height <= pwdata[DIM_W-1:0];
                REG_GRAY:   cfg_reg.gray_input   <= pwdata[0];
                REG_KERNEL: cfg_reg.win_len      <= pwdata[KERNEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            REG_GRAY:   prdata = APB_DATA_W'(cfg_reg.gray_input);
            REG_KERNEL: prdata = APB_DATA_W'(cfg_reg.win_len);
            default:    prdata = '0;
        endcase
    end

endmodule

// File: design/bbec_pixel_mem.sv
module bbec_pixel_mem
    import bbec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  we,
    input  logic [PIX_ADDR_W-1:0] waddr,
    input  logic [PIX_W-1:0]      wdata,
    input  logic                  re,
    input  logic [PIX_ADDR_W-1:0] raddr,
    output logic [PIX_W-1:0]      rdata
);

    logic [PIX_W-1:0] mem [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [PIX_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// File: design/bbec_divider.sv
module bbec_divider
    import bbec_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CHAN_W-1:0] quotient
);

    localparam int STEP_W = $clog2(CHAN_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CHAN_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W:0]    trial;
    logic              ge;

    assign done     = done_reg;
    assign quotient = q_reg;

    // The average never exceeds a channel maximum, so the upper dividend byte is
    // already below the divisor and only the low byte needs restoring steps.
    assign trial = {rem_reg, q_reg[CHAN_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend[SUM_W-1:CHAN_W];
            q_next    = dividend[CHAN_W-1:0];
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? CNT_W'(trial - {1'b0, dsr_reg}) : trial[CNT_W-1:0];
            q_next    = {q_reg[CHAN_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CHAN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> divisor != '0)
        else $error("divider started with a zero count");

    a_div_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> dividend[SUM_W-1:CHAN_W] < divisor)
        else $error("divider quotient would not fit one channel");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

// File: design/box_blur_edge_clipped.sv
// Channel  Direction  Handshake              Word
// config   in         psel/penable/pready    one register write or read (APB)
// s_       in         s_valid/s_ready        req_type, pix_x, pix_y, red/green/blue_in
// m_       out        m_valid/m_ready        red/green/blue_out
//
// A pixel write or an ignored out-of-image request leaves the block idle.
// A blur of N clipped pixels does one store read a cycle, then three 8-step
// restoring divisions on one shared divider; it loads its result into the
// output register once that is free, and only then takes the next word.
// The block takes no item while a blur runs; a finished result waits in the
// output register while the next item is accepted. Reset is synchronous, active low.
module box_blur_edge_clipped
    import bbec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [COORD_W-1:0]    s_pix_x,
    input  logic [COORD_W-1:0]    s_pix_y,
    input  logic [CHAN_W-1:0]     s_red_in,
    input  logic [CHAN_W-1:0]     s_green_in,
    input  logic [CHAN_W-1:0]     s_blue_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAN_W-1:0]     m_red_out,
    output logic [CHAN_W-1:0]     m_green_out,
    output logic [CHAN_W-1:0]     m_blue_out
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_READ      = 3'd1;
    localparam logic [2:0] ST_DRAIN     = 3'd2;
    localparam logic [2:0] ST_DIV_START = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT       = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    cfg_t cfg;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         chan_reg, chan_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [COORD_W-1:0] x0_reg, x0_next;
    logic [COORD_W-1:0] x1_reg, x1_next;
    logic [COORD_W-1:0] y1_reg, y1_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_r_reg, sum_r_next;
    logic [SUM_W-1:0]   sum_g_reg, sum_g_next;
    logic [SUM_W-1:0]   sum_b_reg, sum_b_next;
    logic [CHAN_W-1:0]  res_r_reg, res_r_next;
    logic [CHAN_W-1:0]  res_g_reg, res_g_next;
    logic [CHAN_W-1:0]  res_b_reg, res_b_next;
    logic [CHAN_W-1:0]  m_r_reg, m_r_next;
    logic [CHAN_W-1:0]  m_g_reg, m_g_next;
    logic [CHAN_W-1:0]  m_b_reg, m_b_next;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [RAD_W-1:0]   rad;
    logic               in_acc, in_range, mem_we, mem_re;
    logic [PIX_W-1:0]   rdata;
    logic [DIM_W-1:0]   x_hi, y_hi;
    logic [COORD_W-1:0] x0_win, y0_win, x1_win, y1_win;
    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_dividend;
    logic [CHAN_W-1:0]  div_quotient;

    bbec_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sizes beyond the store saturate to the store dimensions.
    assign w_eff = (cfg.image_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)
                                                           : cfg.image_width;
    assign h_eff = (cfg.image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : cfg.image_height;
    assign rad   = cfg.win_len[KERNEL_W-1:1];

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign in_range = ({1'b0, s_pix_x} < w_eff) && ({1'b0, s_pix_y} < h_eff);
    assign mem_we   = in_acc && in_range && (s_req_type == REQ_WRITE);
    assign mem_re   = (state_reg == ST_READ);

    // Window bounds clipped to the image.
    assign x0_win = (s_pix_x >= COORD_W'(rad)) ? s_pix_x - COORD_W'(rad) : '0;
    assign y0_win = (s_pix_y >= COORD_W'(rad)) ? s_pix_y - COORD_W'(rad) : '0;
    assign x_hi   = {1'b0, s_pix_x} + DIM_W'(rad);
    assign y_hi   = {1'b0, s_pix_y} + DIM_W'(rad);
    assign x1_win = (x_hi < w_eff) ? x_hi[COORD_W-1:0] : COORD_W'(w_eff - 1'b1);
    assign y1_win = (y_hi < h_eff) ? y_hi[COORD_W-1:0] : COORD_W'(h_eff - 1'b1);

    bbec_pixel_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr ({s_pix_y, s_pix_x}),
        .wdata ({s_red_in, s_green_in, s_blue_in}),
        .re    (mem_re),
        .raddr ({cy_reg, cx_reg}),
        .rdata (rdata)
    );

    assign div_start = (state_reg == ST_DIV_START);

    always_comb begin
        case (chan_reg)
            CH_RED:   div_dividend = sum_r_reg;
            CH_GREEN: div_dividend = cfg.gray_input ? sum_r_reg : sum_g_reg;
            CH_BLUE:  div_dividend = cfg.gray_input ? sum_r_reg : sum_b_reg;
            default:  div_dividend = sum_r_reg;
        endcase
    end

    bbec_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next    = state_reg;
        chan_next     = chan_reg;
        rd_valid_next = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        cnt_next      = cnt_reg;
        sum_r_next    = sum_r_reg;
        sum_g_next    = sum_g_reg;
        sum_b_next    = sum_b_reg;
        res_r_next    = res_r_reg;
        res_g_next    = res_g_reg;
        res_b_next    = res_b_reg;
        m_r_next      = m_r_reg;
        m_g_next      = m_g_reg;
        m_b_next      = m_b_reg;

        // Store data arrives the cycle after its read address.
        if (rd_valid_reg) begin
            sum_r_next = sum_r_reg + SUM_W'(rdata[PIX_W-1:2*CHAN_W]);
            sum_g_next = sum_g_reg + SUM_W'(rdata[2*CHAN_W-1:CHAN_W]);
            sum_b_next = sum_b_reg + SUM_W'(rdata[CHAN_W-1:0]);
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_range && (s_req_type == REQ_BLUR)) begin
                    x0_next    = x0_win;
                    x1_next    = x1_win;
                    y1_next    = y1_win;
                    cx_next    = x0_win;
                    cy_next    = y0_win;
                    cnt_next   = '0;
                    sum_r_next = '0;
                    sum_g_next = '0;
                    sum_b_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                rd_valid_next = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cx_reg == x1_reg) begin
                    cx_next = x0_reg;
                    if (cy_reg == y1_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        cy_next = cy_reg + 1'b1;
                    end
                end else begin
                    cx_next = cx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                chan_next  = CH_RED;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    case (chan_reg)
                        CH_RED: begin
                            res_r_next = div_quotient;
                            chan_next  = CH_GREEN;
                            state_next = ST_DIV_START;
                        end
                        CH_GREEN: begin
                            res_g_next = div_quotient;
                            chan_next  = CH_BLUE;
                            state_next = ST_DIV_START;
                        end
                        default: begin
                            res_b_next = div_quotient;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_r_next     = res_r_reg;
                    m_g_next     = res_g_reg;
                    m_b_next     = res_b_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_reg     <= CH_RED;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chan_reg     <= chan_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        cnt_reg   <= cnt_next;
        sum_r_reg <= sum_r_next;
        sum_g_reg <= sum_g_next;
        sum_b_reg <= sum_b_next;
        res_r_reg <= res_r_next;
        res_g_reg <= res_g_next;
        res_b_reg <= res_b_next;
        m_r_reg   <= m_r_next;
        m_g_reg   <= m_g_next;
        m_b_reg   <= m_b_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_r_reg;
    assign m_green_out = m_g_reg;
    assign m_blue_out  = m_b_reg;

`ifndef SYNTHESIS
    a_rd_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(state_reg) == ST_READ)
        else $error("store data flagged without a read issued");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_KERNEL * MAX_KERNEL)))
        else $error("window count out of range at division");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait state");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && (!m_valid_reg || m_ready) |=> m_valid_reg)
        else $error("finished blur did not reach the output register");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import bbec_pkg::*;
();

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int IDLE_PCT    = 23;
    localparam int RANDOM_WORDS = 1000;

    typedef struct {
        logic               req;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
        bit                 drain_first;
    } pix_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = 1'b0;
    logic [COORD_W-1:0]    s_pix_x = '0;
    logic [COORD_W-1:0]    s_pix_y = '0;
    logic [CHAN_W-1:0]     s_red_in = '0;
    logic [CHAN_W-1:0]     s_green_in = '0;
    logic [CHAN_W-1:0]     s_blue_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAN_W-1:0]     m_red_out;
    logic [CHAN_W-1:0]     m_green_out;
    logic [CHAN_W-1:0]     m_blue_out;

    // Shadow of the block: configuration, image contents, and which pixels hold data.
    cfg_t             cur_cfg = '{image_width: 9'd256, image_height: 9'd256,
                                  gray_input: 1'b0, win_len: 4'd5};
    logic [PIX_W-1:0] img_mem [MAX_WIDTH*MAX_HEIGHT];
    bit               img_written [MAX_WIDTH*MAX_HEIGHT];

    pix_req_t req_q[$];
    rgb_t     blur_exp_q[$];
    pix_req_t drv_item;
    int       items_sent = 0;
    int       idle_pct = IDLE_PCT;
    int       mismatch_cnt = 0;
    int       result_cnt = 0;
    int       rx_hold_left = 0;
    int       cyc_cnt = 0;

    box_blur_edge_clipped dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pix_x     (s_pix_x),
        .s_pix_y     (s_pix_y),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int eff_width();
        return (cur_cfg.image_width > MAX_WIDTH) ? MAX_WIDTH : int'(cur_cfg.image_width);
    endfunction

    function automatic int eff_height();
        return (cur_cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_cfg.image_height);
    endfunction

    // Window bounds after clipping against the image edges.
    function automatic void clip_window(input int x, input int y,
                                        output int x0, output int x1,
                                        output int y0, output int y1);
        int k;
        int rad;
        k = (cur_cfg.win_len > MAX_KERNEL) ? MAX_KERNEL : int'(cur_cfg.win_len);
        rad = k / 2;
        x0 = (x >= rad) ? x - rad : 0;
        y0 = (y >= rad) ? y - rad : 0;
        x1 = (x + rad < eff_width()) ? x + rad : eff_width() - 1;
        y1 = (y + rad < eff_height()) ? y + rad : eff_height() - 1;
    endfunction

    function automatic rgb_t blur_window(input int x, input int y);
        int x0, x1, y0, y1, cnt, sr, sg, sb;
        logic [PIX_W-1:0] p;
        rgb_t res;
        sr = 0;
        sg = 0;
        sb = 0;
        clip_window(x, y, x0, x1, y0, y1);
        for (int cy = y0; cy <= y1; cy++) begin
            for (int cx = x0; cx <= x1; cx++) begin
                p = img_mem[cy*MAX_WIDTH + cx];
                sr += p[2*CHAN_W +: CHAN_W];
                sg += p[CHAN_W +: CHAN_W];
                sb += p[0 +: CHAN_W];
            end
        end
        cnt = (x1 - x0 + 1) * (y1 - y0 + 1);
        if (cur_cfg.gray_input) begin
            sg = sr;
            sb = sr;
        end
        res.red = CHAN_W'(sr / cnt);
        res.green = CHAN_W'(sg / cnt);
        res.blue = CHAN_W'(sb / cnt);
        return res;
    endfunction

    // Update the shadow image or queue the expected blur for a word the block took.
    function automatic void apply_item(input pix_req_t it);
        if (it.x >= eff_width() || it.y >= eff_height())
            return;
        if (it.req == REQ_WRITE)
            img_mem[it.y*MAX_WIDTH + it.x] = {it.r, it.g, it.b};
        else
            blur_exp_q.push_back(blur_window(it.x, it.y));
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        if (sel < 20)
            return '1;
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return DIM_W'($urandom_range(1, 16));
        if (sel < 75)
            return DIM_W'($urandom_range(17, 256));
        if (sel < 85)
            return DIM_W'(256);
        if (sel < 90)
            return DIM_W'(1);
        if (sel < 96)
            return DIM_W'($urandom_range(257, 511));
        return '0;
    endfunction

    task automatic push_item(input logic req, input int x, input int y,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
        pix_req_t it;
        it.req = req;
        it.x = COORD_W'(x);
        it.y = COORD_W'(y);
        it.r = r;
        it.g = g;
        it.b = b;
        it.drain_first = (req == REQ_BLUR) && ($urandom_range(0, 49) == 0);
        req_q.push_back(it);
        if (x < eff_width() && y < eff_height()) begin
            items_sent++;
            if (req == REQ_WRITE)
                img_written[y*MAX_WIDTH + x] = 1'b1;
        end
    endtask

    // Writes every pixel of the window that holds no data yet.
    task automatic fill_window(input int x, input int y);
        int x0, x1, y0, y1;
        clip_window(x, y, x0, x1, y0, y1);
        for (int cy = y0; cy <= y1; cy++)
            for (int cx = x0; cx <= x1; cx++)
                if (!img_written[cy*MAX_WIDTH + cx])
                    push_item(REQ_WRITE, cx, cy, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WIDTH:  cur_cfg.image_width = val[DIM_W-1:0];
            REG_HEIGHT: cur_cfg.image_height = val[DIM_W-1:0];
            REG_GRAY:   cur_cfg.gray_input = val[0];
            REG_KERNEL: cur_cfg.win_len = val[KERNEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_read_check(input logic [1:0] idx, input int want);
        logic [APB_DATA_W-1:0] got;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got != want) begin
            $display("%0t: register %0d read expected %0d, got %0d", $time, idx, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic set_config(input int w, input int h, input int gray, input int k);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_GRAY, gray);
        cfg_write(REG_KERNEL, k);
        cfg_read_check(REG_WIDTH, w);
        cfg_read_check(REG_HEIGHT, h);
        cfg_read_check(REG_GRAY, gray);
        cfg_read_check(REG_KERNEL, k);
    endtask

    // Sampled on the falling edge so the driver and monitor have settled.
    task automatic wait_idle();
        do @(negedge aclk);
        while (req_q.size() != 0 || s_valid || blur_exp_q.size() != 0);
        repeat (300) @(posedge aclk);
    endtask

    task automatic random_phase();
        int ew, eh, bw, bh, fx0, fy0, stop_at, sel, x, y;
        set_config(pick_dim(), pick_dim(), $urandom_range(0, 1), $urandom_range(0, 15));
        ew = eff_width();
        eh = eff_height();
        if (ew == 0 || eh == 0) begin
            repeat (6)
                push_item(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                          $urandom_range(0, 255), rand_chan(), rand_chan(), rand_chan());
            wait_idle();
            return;
        end
        // Work stays inside a small box so that blur windows are mostly filled already.
        bw = (ew < 20) ? ew : 20;
        bh = (eh < 20) ? eh : 20;
        case ($urandom_range(0, 2))
            0:       fx0 = 0;
            1:       fx0 = ew - bw;
            default: fx0 = $urandom_range(0, ew - bw);
        endcase
        case ($urandom_range(0, 2))
            0:       fy0 = 0;
            1:       fy0 = eh - bh;
            default: fy0 = $urandom_range(0, eh - bh);
        endcase
        stop_at = items_sent + $urandom_range(60, 120);
        while (items_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            x = fx0 + $urandom_range(0, bw - 1);
            y = fy0 + $urandom_range(0, bh - 1);
            if (sel < 10 && (ew < 256 || eh < 256)) begin
                if (ew < 256 && (eh == 256 || $urandom_range(0, 1) == 1))
                    x = $urandom_range(ew, 255);
                else
                    y = $urandom_range(eh, 255);
                push_item(1'($urandom_range(0, 1)), x, y, rand_chan(), rand_chan(),
                          rand_chan());
            end else if (sel < 45) begin
                push_item(REQ_WRITE, x, y, rand_chan(), rand_chan(), rand_chan());
            end else begin
                fill_window(x, y);
                push_item(REQ_BLUR, x, y, rand_chan(), rand_chan(), rand_chan());
            end
        end
        wait_idle();
    endtask

    // Input driver: one word per handshake, payload held until taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                apply_item(drv_item);
            if (!s_valid || s_ready) begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct
                    && !(req_q[0].drain_first && blur_exp_q.size() != 0)) begin
                    drv_item = req_q.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= drv_item.req;
                    s_pix_x <= drv_item.x;
                    s_pix_y <= drv_item.y;
                    s_red_in <= drv_item.r;
                    s_green_in <= drv_item.g;
                    s_blue_in <= drv_item.b;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor; now and then it refuses results long enough for the block to back up.
    always @(posedge aclk) begin
        rgb_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (blur_exp_q.size() == 0) begin
                    $display("%0t: unexpected result %0d %0d %0d", $time,
                             m_red_out, m_green_out, m_blue_out);
                    mismatch_cnt++;
                end else begin
                    want = blur_exp_q.pop_front();
                    if (m_red_out !== want.red) begin
                        $display("%0t: red_out expected %0d, got %0d", $time, want.red, m_red_out);
                        mismatch_cnt++;
                    end
                    if (m_green_out !== want.green) begin
                        $display("%0t: green_out expected %0d, got %0d", $time,
                                 want.green, m_green_out);
                        mismatch_cnt++;
                    end
                    if (m_blue_out !== want.blue) begin
                        $display("%0t: blue_out expected %0d, got %0d", $time,
                                 want.blue, m_blue_out);
                        mismatch_cnt++;
                    end
                end
                result_cnt++;
                if (result_cnt % 150 == 20)
                    rx_hold_left = 600;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("box_blur_edge_clipped regression: fail");
            $finish;
        end
    end

    initial begin
        int ph;
        ph = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // A 3x2 image with the largest window: every blur averages the whole image.
        set_config(3, 2, 0, 15);
        push_item(REQ_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        push_item(REQ_WRITE, 1, 0, 8'h00, 8'h00, 8'h00);
        push_item(REQ_WRITE, 2, 0, 8'hFF, 8'h00, 8'h80);
        push_item(REQ_WRITE, 0, 1, 8'h01, 8'h02, 8'h03);
        push_item(REQ_WRITE, 1, 1, 8'hFE, 8'hFD, 8'hFC);
        push_item(REQ_WRITE, 2, 1, 8'hFF, 8'hFF, 8'hFF);
        push_item(REQ_WRITE, 3, 0, 8'h55, 8'h55, 8'h55);
        push_item(REQ_BLUR, 0, 2, 8'h00, 8'h00, 8'h00);
        push_item(REQ_BLUR, 0, 0, 8'h00, 8'h00, 8'h00);
        push_item(REQ_BLUR, 2, 1, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // Gray mode with a zero kernel returns channel 0 of the pixel itself.
        set_config(3, 2, 1, 0);
        push_item(REQ_BLUR, 1, 1, 8'h00, 8'h00, 8'h00);
        push_item(REQ_BLUR, 2, 0, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // Oversized dimensions saturate, so the far corner is inside the image.
        set_config(300, 511, 0, 1);
        push_item(REQ_WRITE, 255, 255, 8'h80, 8'h7F, 8'h01);
        push_item(REQ_BLUR, 255, 255, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();
        set_config(511, 256, 1, 2);
        push_item(REQ_WRITE, 254, 254, 8'hFF, 8'h00, 8'hFF);
        push_item(REQ_WRITE, 255, 254, 8'h7F, 8'h80, 8'h00);
        push_item(REQ_WRITE, 254, 255, 8'h00, 8'hFF, 8'h00);
        push_item(REQ_BLUR, 255, 255, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // An empty image ignores everything.
        set_config(0, 256, 0, 5);
        push_item(REQ_WRITE, 0, 0, 8'h12, 8'h34, 8'h56);
        push_item(REQ_BLUR, 0, 0, 8'h00, 8'h00, 8'h00);
        wait_idle();
        set_config(256, 0, 1, 3);
        push_item(REQ_WRITE, 5, 5, 8'h12, 8'h34, 8'h56);
        push_item(REQ_BLUR, 0, 0, 8'h00, 8'h00, 8'h00);
        wait_idle();

        items_sent = 0;
        while (items_sent < RANDOM_WORDS) begin
            idle_pct = (ph == 2 || ph == 3) ? 0 : IDLE_PCT;
            random_phase();
            ph++;
        end

        if (mismatch_cnt == 0)
            $display("box_blur_edge_clipped regression: pass");
        else
            $display("box_blur_edge_clipped regression: fail");
        $finish;
    end

endmodule
